// ===== hw/rtl/rvid_pkg.sv =====
`timescale 1ns / 1ps
// rvid_pkg: shared opcodes, format codes, operation numbers and decode tables
package rvid_pkg;

   // major opcodes
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_IMM    = 7'h13;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_REG    = 7'h33;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   // funct3 codes with special handling
   localparam logic [2:0] F3_ZERO    = 3'd0;
   localparam logic [2:0] F3_SLL     = 3'd1;
   localparam logic [2:0] F3_SW      = 3'd2;
   localparam logic [2:0] F3_SRL     = 3'd5;

   // funct7 codes
   localparam logic [6:0] F7_BASE    = 7'd0;
   localparam logic [6:0] F7_MULDIV  = 7'd1;
   localparam logic [6:0] F7_ALT     = 7'd32;

   localparam int DATA_W = 64;
   localparam int USER_W = 10;

   typedef enum logic [2:0] {
      FMT_R = 3'd0,
      FMT_I = 3'd1,
      FMT_S = 3'd2,
      FMT_B = 3'd3,
      FMT_U = 3'd4,
      FMT_J = 3'd5,
      FMT_X = 3'd6
   } fmt_type;

   typedef enum logic [5:0] {
      OP_LB     = 6'd0,  OP_LH     = 6'd1,  OP_LW     = 6'd2,  OP_LBU    = 6'd3,
      OP_LHU    = 6'd4,  OP_ADDI   = 6'd5,  OP_SLLI   = 6'd6,  OP_SLTI   = 6'd7,
      OP_SLTIU  = 6'd8,  OP_XORI   = 6'd9,  OP_SRLI   = 6'd10, OP_SRAI   = 6'd11,
      OP_ORI    = 6'd12, OP_ANDI   = 6'd13, OP_JALR   = 6'd14, OP_ENV_CALL = 6'd15,
      OP_ADD    = 6'd16, OP_SUB    = 6'd17, OP_SLL    = 6'd18, OP_SLT    = 6'd19,
      OP_SLTU   = 6'd20, OP_XOR    = 6'd21, OP_SRL    = 6'd22, OP_SRA    = 6'd23,
      OP_OR     = 6'd24, OP_AND    = 6'd25, OP_SB     = 6'd26, OP_SH     = 6'd27,
      OP_SW     = 6'd28, OP_BEQ    = 6'd29, OP_BNE    = 6'd30, OP_BLT    = 6'd31,
      OP_BGE    = 6'd32, OP_BLTU   = 6'd33, OP_BGEU   = 6'd34, OP_ADD_UPPER_PC = 6'd35,
      OP_LUI    = 6'd36, OP_JAL    = 6'd37, OP_MUL    = 6'd38, OP_MULH   = 6'd39,
      OP_MULHSU = 6'd40, OP_MULHU  = 6'd41, OP_DIV    = 6'd42, OP_DIVU   = 6'd43,
      OP_REM    = 6'd44, OP_REMU   = 6'd45, OP_NONE   = 6'd46
   } op_type;

   // per-funct3 tables, index 0 first
   localparam op_type LOAD_OPS [8] = '{OP_LB, OP_LH, OP_LW, OP_NONE,
                                       OP_LBU, OP_LHU, OP_NONE, OP_NONE};
   localparam op_type IMM_OPS [8] = '{OP_ADDI, OP_NONE, OP_SLTI, OP_SLTIU,
                                      OP_XORI, OP_NONE, OP_ORI, OP_ANDI};
   localparam op_type BRANCH_OPS [8] = '{OP_BEQ, OP_BNE, OP_NONE, OP_NONE,
                                         OP_BLT, OP_BGE, OP_BLTU, OP_BGEU};
   localparam op_type REG_OPS [8] = '{OP_ADD, OP_SLL, OP_SLT, OP_SLTU,
                                      OP_XOR, OP_SRL, OP_OR, OP_AND};
   localparam op_type MULDIV_OPS [8] = '{OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU,
                                         OP_DIV, OP_DIVU, OP_REM, OP_REMU};
   localparam op_type STORE_OPS [3] = '{OP_SB, OP_SH, OP_SW};

   typedef struct packed {
      logic [6:0]  major_opcode;
      logic [4:0]  dest_reg;
      logic [2:0]  func3;
      logic [4:0]  src1_reg;
      logic [4:0]  src2_reg;
      logic [6:0]  func7;
      logic [31:0] immediate;
      fmt_type     format_code;
      op_type      operation;
      logic        legal;
   } result_type;

endpackage

// ===== hw/rtl/rvid_decode.sv =====
`timescale 1ns / 1ps
// rvid_decode: combinational field split, format, immediate and operation decode
module rvid_decode (
   input  logic [31:0]               instr_word,
   output rvid_pkg::result_type      result
);

   logic [6:0]        opc;
   logic [2:0]        f3;
   logic [6:0]        f7;
   rvid_pkg::fmt_type fmt;
   rvid_pkg::op_type  op;
   logic [31:0]       imm;

   assign opc = instr_word[6:0];
   assign f3  = instr_word[14:12];
   assign f7  = instr_word[31:25];

   // format and operation
   always_comb begin
      fmt = rvid_pkg::FMT_X;
      op  = rvid_pkg::OP_NONE;
      unique case (opc)
         rvid_pkg::OPC_LOAD: begin
            fmt = rvid_pkg::FMT_I;
            op  = rvid_pkg::LOAD_OPS[f3];
         end
         rvid_pkg::OPC_IMM: begin
            fmt = rvid_pkg::FMT_I;
            if (f3 == rvid_pkg::F3_SLL) begin
               op = (f7 == rvid_pkg::F7_BASE) ? rvid_pkg::OP_SLLI : rvid_pkg::OP_NONE;
            end else if (f3 == rvid_pkg::F3_SRL) begin
               if (f7 == rvid_pkg::F7_BASE) op = rvid_pkg::OP_SRLI;
               else if (f7 == rvid_pkg::F7_ALT) op = rvid_pkg::OP_SRAI;
               else op = rvid_pkg::OP_NONE;
            end else begin
               op = rvid_pkg::IMM_OPS[f3];
            end
         end
         rvid_pkg::OPC_JALR: begin
            fmt = rvid_pkg::FMT_I;
            op  = (f3 == rvid_pkg::F3_ZERO) ? rvid_pkg::OP_JALR : rvid_pkg::OP_NONE;
         end
         rvid_pkg::OPC_SYSTEM: begin
            fmt = rvid_pkg::FMT_I;
            op  = (f3 == rvid_pkg::F3_ZERO) ? rvid_pkg::OP_ENV_CALL : rvid_pkg::OP_NONE;
         end
         rvid_pkg::OPC_REG: begin
            fmt = rvid_pkg::FMT_R;
            if (f7 == rvid_pkg::F7_BASE) begin
               op = rvid_pkg::REG_OPS[f3];
            end else if (f7 == rvid_pkg::F7_ALT) begin
               if (f3 == rvid_pkg::F3_ZERO) op = rvid_pkg::OP_SUB;
               else if (f3 == rvid_pkg::F3_SRL) op = rvid_pkg::OP_SRA;
               else op = rvid_pkg::OP_NONE;
            end else if (f7 == rvid_pkg::F7_MULDIV) begin
               op = rvid_pkg::MULDIV_OPS[f3];
            end else begin
               op = rvid_pkg::OP_NONE;
            end
         end
         rvid_pkg::OPC_STORE: begin
            fmt = rvid_pkg::FMT_S;
            op  = (f3 <= rvid_pkg::F3_SW) ? rvid_pkg::STORE_OPS[f3[1:0]] : rvid_pkg::OP_NONE;
         end
         rvid_pkg::OPC_BRANCH: begin
            fmt = rvid_pkg::FMT_B;
            op  = rvid_pkg::BRANCH_OPS[f3];
         end
         rvid_pkg::OPC_AUIPC: begin
            fmt = rvid_pkg::FMT_U;
            op  = rvid_pkg::OP_ADD_UPPER_PC;
         end
         rvid_pkg::OPC_LUI: begin
            fmt = rvid_pkg::FMT_U;
            op  = rvid_pkg::OP_LUI;
         end
         rvid_pkg::OPC_JAL: begin
            fmt = rvid_pkg::FMT_J;
            op  = rvid_pkg::OP_JAL;
         end
         default: begin
            fmt = rvid_pkg::FMT_X;
            op  = rvid_pkg::OP_NONE;
         end
      endcase
   end

   // immediate assembly by format
   always_comb begin
      unique case (fmt)
         rvid_pkg::FMT_I: imm = {{20{instr_word[31]}}, instr_word[31:20]};
         rvid_pkg::FMT_S: imm = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
         rvid_pkg::FMT_B: imm = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                                 instr_word[30:25], instr_word[11:8], 1'b0};
         rvid_pkg::FMT_U: imm = {instr_word[31:12], 12'd0};
         rvid_pkg::FMT_J: imm = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                                 instr_word[20], instr_word[30:21], 1'b0};
         default:         imm = 32'd0;
      endcase
   end

   always_comb begin
      result.major_opcode = opc;
      result.dest_reg     = instr_word[11:7];
      result.func3        = f3;
      result.src1_reg     = instr_word[19:15];
      result.src2_reg     = instr_word[24:20];
      result.func7        = f7;
      result.immediate    = imm;
      result.format_code  = fmt;
      result.operation    = op;
      result.legal        = (op != rvid_pkg::OP_NONE);
   end

endmodule

// ===== hw/rtl/rvid_out_stage.sv =====
`timescale 1ns / 1ps
// rvid_out_stage: result register and response channel packing
module rvid_out_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  rvid_pkg::result_type          in_result,
   output logic                          in_ready,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rvid_pkg::DATA_W-1:0]   rsp_tdata,
   output logic [rvid_pkg::USER_W-1:0]   rsp_tuser
);

   logic                 valid_ff;
   logic                 valid_in;
   rvid_pkg::result_type result_ff;
   rvid_pkg::result_type result_in;

   // stage frees up when empty or when the held result leaves this cycle
   assign in_ready  = !valid_ff || rsp_tready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign result_in = (in_ready && in_valid) ? in_result : result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {result_ff.immediate, result_ff.func7, result_ff.src2_reg,
                        result_ff.src1_reg, result_ff.func3, result_ff.dest_reg,
                        result_ff.major_opcode};
   assign rsp_tuser  = {result_ff.legal, result_ff.operation, result_ff.format_code};

endmodule

// ===== hw/rtl/rv32im_instruction_decoder_unit.sv =====
`timescale 1ns / 1ps
// rv32im_instruction_decoder_unit: top level of the rv32im instruction decoder
//
//   channel | ports                | direction | content
//   --------+----------------------+-----------+--------------------------------
//   req     | req_tvalid/tready    | in        | tdata[31:0] instr_word
//           | req_tdata            |           |
//   rsp     | rsp_tvalid/tready    | out       | tdata: decoded fields + immediate
//           | rsp_tdata, rsp_tuser |           | tuser: format, operation, legal
//
// one request per cycle sustained while rsp_tready stays high; an accepted request
// passes the input register, then decode logic into the result register (rsp_tvalid)
// reset is synchronous and active high and empties both stages
// a stalled rsp fills the result register and then the input register, after
// which req_tready drops until rsp_tready returns
module rv32im_instruction_decoder_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [31:0]                   req_tdata,   // [31:0] instr_word
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [6:0] major_opcode, [11:7] dest_reg, [14:12] func3, [19:15] src1_reg,
   // [24:20] src2_reg, [31:25] func7, [63:32] immediate
   output logic [rvid_pkg::DATA_W-1:0]   rsp_tdata,
   // [2:0] format_code, [8:3] operation, [9] legal
   output logic [rvid_pkg::USER_W-1:0]   rsp_tuser
);

   // input register
   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [31:0]          in_word_ff;
   logic [31:0]          in_word_in;

   // decode to result stage
   rvid_pkg::result_type dec_result;
   logic                 dec_ready;

   // input register takes a new request when empty or when its word moves on
   assign req_tready  = !in_valid_ff || dec_ready;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign in_word_in  = (req_tvalid && req_tready) ? req_tdata : in_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
   end

   // field split, format, immediate and operation lookup
   rvid_decode u_decode (
      .instr_word (in_word_ff),
      .result     (dec_result)
   );

   // result register feeding the response channel
   rvid_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (in_valid_ff),
      .in_result  (dec_result),
      .in_ready   (dec_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
